@@ rtl/mrpq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrpq_pkg
// Shared constants, entry layout and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mrpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  // Wide enough that the push order never wraps in practice.
  localparam int STAMP_W  = 48;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_BELOW = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   val;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic push;
    logic pop_empty;
    logic scan_start;
    logic scan_step;
    logic move_rd;
    logic move_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_push;
    logic empty;
    logic scan_done;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/mrpq_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrpq_datapath
// Entry memory kept dense in slots 0..count-1, minimum scan, pop compaction.
// ----------------------------------------------------------------------------
module mrpq_datapath (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire mrpq_pkg::dp_cmd_t   cmd,
  output mrpq_pkg::dp_stat_t       stat,
  input  wire                      in_opcode,
  input  wire [mrpq_pkg::KEY_W-1:0] in_item_key,
  input  wire [mrpq_pkg::VAL_W-1:0] in_item_value,
  output mrpq_pkg::status_t        res_status,
  output logic [mrpq_pkg::KEY_W-1:0] res_key,
  output logic [mrpq_pkg::VAL_W-1:0] res_val,
  output logic [mrpq_pkg::CNT_W-1:0] count
);
  import mrpq_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  logic               op_r;
  logic [KEY_W-1:0]   key_in_r;
  logic [VAL_W-1:0]   val_in_r;
  logic [CNT_W-1:0]   count_r;
  logic [KEY_W-1:0]   last_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [CNT_W-1:0]   idx_r;
  logic               pend_r;
  logic [ADDR_W-1:0]  pend_idx_r;
  logic               best_vld_r;
  logic [ADDR_W-1:0]  best_idx_r;
  entry_t             best_r;
  status_t            res_status_r;
  logic [KEY_W-1:0]   res_key_r;
  logic [VAL_W-1:0]   res_val_r;

  logic        better;
  logic        wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t      wr_data;
  logic        rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  last_slot;

  assign last_slot = count_r - CNT_W'(1);

  assign better = !best_vld_r || (rd_data_r.key < best_r.key) ||
                  ((rd_data_r.key == best_r.key) && (rd_data_r.stamp > best_r.stamp));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[ADDR_W-1:0];
    wr_data = '{key: key_in_r, val: val_in_r, stamp: stamp_r};
    if (cmd.push && !(key_in_r < last_r) && (count_r != CNT_W'(CAPACITY))) begin
      wr_en = 1'b1;
    end else if (cmd.move_wr) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = rd_data_r;
    end
    rd_en   = 1'b0;
    rd_addr = idx_r[ADDR_W-1:0];
    if (cmd.scan_step && (idx_r < count_r)) begin
      rd_en = 1'b1;
    end else if (cmd.move_rd) begin
      rd_en   = 1'b1;
      rd_addr = last_slot[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      last_r     <= '0;
      stamp_r    <= '0;
      idx_r      <= '0;
      pend_r     <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r     <= in_opcode;
        key_in_r <= in_item_key;
        val_in_r <= in_item_value;
      end
      if (cmd.push) begin
        res_key_r <= '0;
        res_val_r <= '0;
        if (key_in_r < last_r) begin
          res_status_r <= ST_BELOW;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          res_status_r <= ST_FULL;
        end else begin
          res_status_r <= ST_OK;
          count_r      <= count_r + CNT_W'(1);
          stamp_r      <= stamp_r + STAMP_W'(1);
        end
      end
      if (cmd.pop_empty) begin
        res_status_r <= ST_EMPTY;
        res_key_r    <= '0;
        res_val_r    <= '0;
      end
      if (cmd.scan_start) begin
        idx_r      <= '0;
        pend_r     <= 1'b0;
        best_vld_r <= 1'b0;
      end else begin
        pend_r     <= rd_en && cmd.scan_step;
        pend_idx_r <= idx_r[ADDR_W-1:0];
        if (rd_en && cmd.scan_step) begin
          idx_r <= idx_r + CNT_W'(1);
        end
        if (pend_r && better) begin
          best_vld_r <= 1'b1;
          best_idx_r <= pend_idx_r;
          best_r     <= rd_data_r;
        end
      end
      if (cmd.move_wr) begin
        res_status_r <= ST_OK;
        res_key_r    <= best_r.key;
        res_val_r    <= best_r.val;
        last_r       <= best_r.key;
        count_r      <= last_slot;
      end
    end
  end

  assign stat.is_push   = !op_r;
  assign stat.empty     = (count_r == '0);
  assign stat.scan_done = (idx_r == count_r) && !pend_r;
  assign res_status     = res_status_r;
  assign res_key        = res_key_r;
  assign res_val        = res_val_r;
  assign count          = count_r;

endmodule
`default_nettype wire

@@ rtl/mrpq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrpq_ctrl
// Sequencer: accept, decode, push or empty check, scan for minimum, compact, present result.
// ----------------------------------------------------------------------------
module mrpq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output mrpq_pkg::dp_cmd_t   cmd,
  input  wire mrpq_pkg::dp_stat_t stat
);
  import mrpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_POP, S_SCAN, S_MRD, S_MWR, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_push) begin
          cmd.push  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (stat.empty) begin
          cmd.pop_empty = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_MRD;
      end
      S_MRD: begin
        cmd.move_rd = 1'b1;
        state_nxt   = S_MWR;
      end
      S_MWR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule
`default_nettype wire

@@ rtl/monotone_radix_priority_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// monotone_radix_priority_queue
// Monotone min-priority queue of up to 1024 key/value entries.
// ----------------------------------------------------------------------------
// One item at a time. A push, stored or faulted, is decoded and then hands
// over its result; a pop on an empty queue is decoded, found empty and then
// hands over its fault; any other pop scans all n stored entries for the
// minimum key (ties go to the most recent push) in the single-port entry
// memory, so its time is set by that linear scan. The next item is taken
// only after the result is accepted. Entries are kept packed, so a pop moves
// the last entry into the freed slot. No clearing pass is needed after reset.
module monotone_radix_priority_queue (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_opcode,
  input  wire [mrpq_pkg::KEY_W-1:0]    in_item_key,
  input  wire [mrpq_pkg::VAL_W-1:0]    in_item_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [1:0]                   out_status,
  output logic [mrpq_pkg::KEY_W-1:0]   out_popped_key,
  output logic [mrpq_pkg::VAL_W-1:0]   out_popped_value,
  output logic                         out_is_empty,
  output logic [mrpq_pkg::CNT_W-1:0]   out_entry_total
);
  import mrpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mrpq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .stat(stat)
  );

  mrpq_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cmd(cmd), .stat(stat),
    .in_opcode(in_opcode), .in_item_key(in_item_key), .in_item_value(in_item_value),
    .res_status(out_status), .res_key(out_popped_key), .res_val(out_popped_value),
    .count(out_entry_total)
  );

  assign out_is_empty = (out_entry_total == '0);

endmodule
`default_nettype wire

@@ rtl/mrpq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mrpq_checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
module mrpq_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire        out_is_empty,
  input wire [10:0] out_entry_total
);
  import mrpq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_total) && $stable(out_status))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("second transaction taken while busy");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_total == 11'd0)))
    else $error("empty flag disagrees with count");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_entry_total == 11'(CAPACITY)))
    else $error("full fault below capacity");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_is_empty)
    else $error("empty fault with entries stored");

endmodule

bind monotone_radix_priority_queue mrpq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_is_empty(out_is_empty), .out_entry_total(out_entry_total)
);
`default_nettype wire

@@ dv/monotone_radix_priority_queue_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// monotone_radix_priority_queue_tb
// Self-checking bench: directed table, then monotone push/pop traffic with a
// fill to capacity, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module monotone_radix_priority_queue_tb;
  import mrpq_pkg::*;

  localparam bit            OP_PUSH   = 1'b0;
  localparam bit            OP_POP    = 1'b1;
  localparam logic [30:0]   KEY_MAX   = 31'h7FFF_FFFF;
  localparam int            RUN_LIMIT = 10_000_000;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    logic             empty;
    logic [CNT_W-1:0] total;
  } result_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    longint unsigned  stamp;
  } held_entry_t;

  typedef struct {
    bit               op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] val;
    bit               typed;
    result_t          res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_opcode = 1'b0;
  logic [KEY_W-1:0] in_item_key = '0;
  logic [VAL_W-1:0] in_item_value = '0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, out_is_empty;
  logic [1:0] out_status;
  logic [KEY_W-1:0] out_popped_key;
  logic [VAL_W-1:0] out_popped_value;
  logic [CNT_W-1:0] out_entry_total;

  // queue contents as the predictor sees them
  held_entry_t      held[$];
  logic [KEY_W-1:0] floor_key = '0;
  longint unsigned  push_seq = 0;

  result_t pending_results[$];
  int  err_cnt = 0;
  int  cycle_cnt = 0;
  bit  long_hold_req = 0;
  int  n_push = 0, n_pop = 0, n_empty = 0, n_below = 0, n_full = 0, max_fill = 0;

  monotone_radix_priority_queue u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_item_key, .in_item_value,
    .out_valid, .out_ready, .out_status, .out_popped_key, .out_popped_value,
    .out_is_empty, .out_entry_total
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("monotone_radix_priority_queue test failed");
      $finish;
    end
  end

  // Predict one item: min key wins, ties go to the latest push.
  function automatic result_t predict_queue(bit op, logic [KEY_W-1:0] key,
                                            logic [VAL_W-1:0] val);
    result_t r;
    int best;
    held_entry_t e;
    r = '{ST_OK, '0, '0, 1'b0, '0};
    if (op == OP_PUSH) begin
      if (key < floor_key) r.status = ST_BELOW;
      else if (held.size() >= CAPACITY) r.status = ST_FULL;
      else begin
        e.key = key; e.val = val; e.stamp = push_seq++;
        held.insert(held.size(), e);
      end
    end else if (held.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      foreach (held[i])
        if (held[i].key < held[best].key ||
            (held[i].key == held[best].key && held[i].stamp > held[best].stamp))
          best = i;
      r.key = held[best].key;
      r.val = held[best].val;
      floor_key = held[best].key;
      held.delete(best);
    end
    r.empty = (held.size() == 0);
    r.total = CNT_W'(held.size());
    return r;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly legal monotone keys; some ties, some faults.
  function automatic logic [KEY_W-1:0] next_key();
    longint k;
    int p;
    p = $urandom_range(0, 99);
    k = floor_key;
    if (p < 40) k = k + $urandom_range(0, 15);
    else if (p < 60) k = k;
    else if (p < 85) k = k + $urandom_range(0, 65535);
    else if (p < 88) k = k + ({$urandom} % (longint'(KEY_MAX) - k + 1));
    else if (p < 90) k = KEY_MAX;
    else if (p < 97) k = (floor_key == 0) ? 0 : $urandom_range(0, floor_key - 1);
    else k = $urandom & KEY_MAX;
    if (k > KEY_MAX) k = KEY_MAX;
    return k[KEY_W-1:0];
  endfunction

  task automatic send_item(bit op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val,
                           bit typed, result_t typed_res);
    int gap;
    result_t r;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_item_key   <= key;
    in_item_value <= val;
    // in_ready is sampled at the edge, before the design updates
    @(posedge clk iff in_ready);
    r = predict_queue(op, key, val);
    pending_results.insert(pending_results.size(), typed ? typed_res : r);
    case (r.status)
      ST_OK:    if (op == OP_PUSH) n_push++; else n_pop++;
      ST_EMPTY: n_empty++;
      ST_BELOW: n_below++;
      default:  n_full++;
    endcase
    if (held.size() > max_fill) max_fill = held.size();
  endtask

  task automatic send_random(int pop_pct);
    result_t none;
    none = '{ST_OK, '0, '0, 1'b0, '0};
    if ($urandom_range(0, 99) < pop_pct)
      send_item(OP_POP, KEY_W'($urandom), $urandom, 1'b0, none);
    else
      send_item(OP_PUSH, next_key(), $urandom, 1'b0, none);
  endtask

  dir_row_t dir_rows [0:13] = '{
    '{OP_POP,  31'h0,        32'h0,         1, '{ST_EMPTY, 31'h0,   32'h0,         1, 0}},
    '{OP_PUSH, KEY_MAX,      32'hFFFF_FFFF, 1, '{ST_OK,    31'h0,   32'h0,         0, 1}},
    '{OP_PUSH, 31'h0,        32'h0,         1, '{ST_OK,    31'h0,   32'h0,         0, 2}},
    '{OP_POP,  KEY_MAX,      32'hFFFF_FFFF, 1, '{ST_OK,    31'h0,   32'h0,         0, 1}},
    '{OP_PUSH, 31'h5,        32'hAAAA_5555, 0, '{ST_OK,    31'h0,   32'h0,         0, 0}},
    '{OP_PUSH, 31'h5,        32'h5555_AAAA, 0, '{ST_OK,    31'h0,   32'h0,         0, 0}},
    '{OP_POP,  31'h0,        32'h0,         1, '{ST_OK,    31'h5,   32'h5555_AAAA, 0, 2}},
    '{OP_PUSH, 31'h3,        32'h1234_5678, 1, '{ST_BELOW, 31'h0,   32'h0,         0, 2}},
    '{OP_PUSH, 31'h100,      32'h1234_5678, 0, '{ST_OK,    31'h0,   32'h0,         0, 0}},
    '{OP_POP,  31'h0,        32'h0,         1, '{ST_OK,    31'h5,   32'hAAAA_5555, 0, 2}},
    '{OP_POP,  31'h0,        32'h0,         1, '{ST_OK,    31'h100, 32'h1234_5678, 0, 1}},
    '{OP_PUSH, 31'h100,      32'h0,         0, '{ST_OK,    31'h0,   32'h0,         0, 0}},
    '{OP_POP,  31'h0,        32'h0,         1, '{ST_OK,    31'h100, 32'h0,         0, 1}},
    '{OP_PUSH, 31'hFF,       32'hFFFF_FFFF, 1, '{ST_BELOW, 31'h0,   32'h0,         0, 1}}
  };

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].val,
                dir_rows[i].typed, dir_rows[i].res);
    repeat (150) send_random(45);
    // fill to capacity, a few pushes into a full store, with a long stall
    long_hold_req = 1;
    n = 0;
    while (held.size() < CAPACITY && n < 1400) begin
      send_random(2);
      n++;
    end
    repeat (4) send_item(OP_PUSH, floor_key, $urandom, 1'b0, '{ST_OK, '0, '0, 0, 0});
    repeat (150) send_random(50);
    repeat (250) send_random(70);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d good pushes, %0d good pops, peak fill %0d of %0d.",
             n_push, n_pop, max_fill, CAPACITY);
    $display("Faults: %0d pops on empty, %0d keys below floor, %0d full pushes.",
             n_empty, n_below, n_full);
    if (err_cnt == 0) $display("monotone_radix_priority_queue test passed");
    else $display("monotone_radix_priority_queue test failed");
    $finish;
  end

  // output side: random backpressure, one long hold-off during the fill
  initial begin
    forever begin
      if (long_hold_req) begin
        long_hold_req = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        repeat (1 + idle_len()) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending, status %0d", $time, out_status);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, out_status);
          err_cnt++;
        end
        if (out_popped_key !== exp_r.key) begin
          $display("%0t: key exp %h got %h", $time, exp_r.key, out_popped_key);
          err_cnt++;
        end
        if (out_popped_value !== exp_r.val) begin
          $display("%0t: value exp %h got %h", $time, exp_r.val, out_popped_value);
          err_cnt++;
        end
        if (out_is_empty !== exp_r.empty) begin
          $display("%0t: empty exp %0d got %0d", $time, exp_r.empty, out_is_empty);
          err_cnt++;
        end
        if (out_entry_total !== exp_r.total) begin
          $display("%0t: total exp %0d got %0d", $time, exp_r.total, out_entry_total);
          err_cnt++;
        end
      end
    end
  end

endmodule
